// ===== sv/pd_differential_drive_core_assert.svh =====
// Assertion macros for the differential drive PD controller checker.
// Needs clk and rst_n in scope where the macros are used.
`ifndef PD_DIFFERENTIAL_DRIVE_CORE_ASSERT_SVH
`define PD_DIFFERENTIAL_DRIVE_CORE_ASSERT_SVH

// antecedent holds -> consequent holds in the next cycle
`define PDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pd drive: next-cycle check failed");

// antecedent sequence ends -> consequent holds in that cycle
`define PDD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pd drive: same-cycle check failed");

`endif

// ===== sv/pdd_pkg.sv =====
// Shared constants for the differential drive PD controller.
// No dependencies; used by the core, the serial multiplier and the checker.
package pdd_pkg;

    localparam int FIELD_W    = 16;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KD     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RBASE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LBASE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX    = 3'd6;

    localparam logic [FIELD_W-1:0] KP_RESET     = 16'd256;
    localparam logic [FIELD_W-1:0] KD_RESET     = 16'd0;
    localparam logic [FIELD_W-1:0] PERIOD_RESET = 16'd256;
    localparam logic [FIELD_W-1:0] BASE_RESET   = 16'd0;
    localparam logic [FIELD_W-1:0] MIN_RESET    = 16'd0;
    localparam logic [FIELD_W-1:0] MAX_RESET    = 16'd255;

    localparam logic [FIELD_W-1:0] CORR_MAX = 16'h7FFF;
    localparam logic [FIELD_W-1:0] CORR_MIN = 16'h8000;

    // serial multiplier: 32-bit multiplicand, 17-bit multiplier, one bit per cycle
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_B_W - 1);

    // restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = FIELD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

endpackage

// ===== sv/pd_differential_drive_core.sv =====
// Differential drive PD controller: error, derivative, correction, clamped motor speeds.
// Depends on pdd_pkg and pdd_sermul (two instances).
//
//  channel  | signals                                    | transfer when
//  ---------+--------------------------------------------+-------------------------------
//  in       | in_valid, in_ready, target, measured       | in_valid & in_ready
//  out      | out_valid, out_ready, right/left_speed,    | out_valid & out_ready
//           | correction                                 |
//  cfg      | psel, penable, pwrite, paddr, pwdata,      | psel & penable & pwrite
//           | prdata, pready                             |
//
// One item at a time: from input transfer to result in the output register, the item
// runs two 17-step serial multiplies in series (kp*err, then *period; kd*delta runs
// alongside the first) and a 16-step restoring divide by the period.
// in_ready is high only in idle, so no new item is taken until the last one is loaded.
// The output register holds a finished result while the next item computes;
// a stalled output delays the following item's final load and keeps in_ready low.
// Async active-low reset; state and config regs come up at their documented defaults.
module pd_differential_drive_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pdd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pdd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pdd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [pdd_pkg::FIELD_W-1:0] target,
    input  logic signed [pdd_pkg::FIELD_W-1:0] measured,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [pdd_pkg::FIELD_W-1:0] right_speed,
    output logic signed [pdd_pkg::FIELD_W-1:0] left_speed,
    output logic signed [pdd_pkg::FIELD_W-1:0] correction
);
    import pdd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1_GO,
        ST_MUL1_WAIT,
        ST_MUL2_GO,
        ST_MUL2_WAIT,
        ST_SUM1,
        ST_SUM2,
        ST_ABS,
        ST_CHK,
        ST_DIV,
        ST_SAT,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 out_valid_reg;

    logic [FIELD_W-1:0]   kp_gain_reg;
    logic [FIELD_W-1:0]   kd_gain_reg;
    logic [FIELD_W-1:0]   sample_period_reg;
    logic [FIELD_W-1:0]   right_base_reg;
    logic [FIELD_W-1:0]   left_base_reg;
    logic [FIELD_W-1:0]   min_speed_reg;
    logic [FIELD_W-1:0]   max_speed_reg;
    logic [FIELD_W:0]     prev_err_reg;

    logic [FIELD_W-1:0]   err_mag_reg;
    logic [FIELD_W:0]     dlt_mag_reg;
    logic                 sign_a_reg;
    logic                 sign_b_reg;
    logic [MUL_P_W-1:0]   num_reg;
    logic [MUL_P_W-2:0]   mag_reg;
    logic                 neg_reg;
    logic                 ovf_reg;
    logic [FIELD_W-1:0]   rem_reg;
    logic [FIELD_W-1:0]   quo_reg;
    logic [FIELD_W-1:0]   corr_reg;
    logic [FIELD_W-1:0]   right_speed_reg;
    logic [FIELD_W-1:0]   left_speed_reg;
    logic [FIELD_W-1:0]   correction_reg;

    logic                 in_xfer;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 out_free;
    logic [FIELD_W:0]     err_w;
    logic [FIELD_W+1:0]   dlt_w;
    logic [FIELD_W:0]     err_neg_w;
    logic [FIELD_W+1:0]   dlt_neg_w;
    logic [FIELD_W-1:0]   kp_abs;
    logic [FIELD_W-1:0]   kd_abs;
    logic [FIELD_W-1:0]   period_eff;
    logic                 start_a;
    logic                 start_b;
    logic [MUL_A_W-1:0]   mcand_a;
    logic [MUL_B_W-1:0]   mplier_a;
    logic [MUL_P_W-1:0]   prod_a;
    logic [MUL_P_W-1:0]   prod_b;
    logic                 done_a;
    logic                 done_b;
    logic [MUL_P_W-1:0]   term_b;
    logic [MUL_P_W-1:0]   num_neg_w;
    logic [FIELD_W:0]     div_cat_w;
    logic [FIELD_W:0]     div_try_w;
    logic                 div_ge;
    logic [FIELD_W-1:0]   quo_neg_w;
    logic [FIELD_W:0]     rsp_w;
    logic [FIELD_W:0]     lsp_w;

    function automatic logic [FIELD_W-1:0] clamp_speed(
        input logic [FIELD_W:0]   v,
        input logic [FIELD_W-1:0] lo,
        input logic [FIELD_W-1:0] hi
    );
        logic signed [FIELD_W:0] s;
        logic signed [FIELD_W:0] s_lo;
        logic signed [FIELD_W:0] s_hi;
        s    = v;
        s_lo = {lo[FIELD_W-1], lo};
        s_hi = {hi[FIELD_W-1], hi};
        if (s > s_hi)
        begin
            s = s_hi;
        end
        if (s < s_lo)
        begin
            s = s_lo;
        end
        return s[FIELD_W-1:0];
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[APB_ADDR_W-1:2];
    assign pready   = 1'b1;

    assign err_w     = {target[FIELD_W-1], target} - {measured[FIELD_W-1], measured};
    assign dlt_w     = {err_w[FIELD_W], err_w} - {prev_err_reg[FIELD_W], prev_err_reg};
    assign err_neg_w = -err_w;
    assign dlt_neg_w = -dlt_w;
    assign kp_abs    = kp_gain_reg[FIELD_W-1] ? -kp_gain_reg : kp_gain_reg;
    assign kd_abs    = kd_gain_reg[FIELD_W-1] ? -kd_gain_reg : kd_gain_reg;
    assign period_eff = (sample_period_reg == '0) ? 16'd1 : sample_period_reg;

    assign start_a  = (state_reg == ST_MUL1_GO) || (state_reg == ST_MUL2_GO);
    assign start_b  = (state_reg == ST_MUL1_GO);
    assign mcand_a  = (state_reg == ST_MUL2_GO) ? prod_a[MUL_A_W-1:0]
                                                : {{(MUL_A_W-FIELD_W){1'b0}}, err_mag_reg};
    assign mplier_a = (state_reg == ST_MUL2_GO) ? {1'b0, period_eff} : {1'b0, kp_abs};

    pdd_sermul u_mul_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_a),
        .mcand   (mcand_a),
        .mplier  (mplier_a),
        .product (prod_a),
        .done    (done_a)
    );

    pdd_sermul u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_b),
        .mcand   ({{(MUL_A_W-FIELD_W){1'b0}}, kd_abs}),
        .mplier  (dlt_mag_reg),
        .product (prod_b),
        .done    (done_b)
    );

    // kd*delta*256 over the common denominator 256*period
    assign term_b    = {prod_b[MUL_P_W-9:0], 8'b0};
    assign num_neg_w = -num_reg;

    // divide |num|/256 by period; low 8 bits of the dividend drop out
    assign div_cat_w = {rem_reg, quo_reg[FIELD_W-1]};
    assign div_ge    = div_cat_w >= {1'b0, period_eff};
    assign div_try_w = div_cat_w - {1'b0, period_eff};
    assign quo_neg_w = -quo_reg;

    assign rsp_w = {right_base_reg[FIELD_W-1], right_base_reg}
                 + {corr_reg[FIELD_W-1], corr_reg};
    assign lsp_w = {left_base_reg[FIELD_W-1], left_base_reg}
                 - {corr_reg[FIELD_W-1], corr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
            kp_gain_reg       <= KP_RESET;
            kd_gain_reg       <= KD_RESET;
            sample_period_reg <= PERIOD_RESET;
            right_base_reg    <= BASE_RESET;
            left_base_reg     <= BASE_RESET;
            min_speed_reg     <= MIN_RESET;
            max_speed_reg     <= MAX_RESET;
            prev_err_reg      <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_KP:     kp_gain_reg       <= pwdata[FIELD_W-1:0];
                    REG_KD:     kd_gain_reg       <= pwdata[FIELD_W-1:0];
                    REG_PERIOD: sample_period_reg <= pwdata[FIELD_W-1:0];
                    REG_RBASE:  right_base_reg    <= pwdata[FIELD_W-1:0];
                    REG_LBASE:  left_base_reg     <= pwdata[FIELD_W-1:0];
                    REG_MIN:    min_speed_reg     <= pwdata[FIELD_W-1:0];
                    REG_MAX:    max_speed_reg     <= pwdata[FIELD_W-1:0];
                    default:    ;
                endcase
            end

            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        prev_err_reg <= err_w;
                        state_reg    <= ST_MUL1_GO;
                    end
                end
                ST_MUL1_GO:   state_reg <= ST_MUL1_WAIT;
                ST_MUL1_WAIT:
                begin
                    if (done_a && done_b)
                    begin
                        state_reg <= ST_MUL2_GO;
                    end
                end
                ST_MUL2_GO:   state_reg <= ST_MUL2_WAIT;
                ST_MUL2_WAIT:
                begin
                    if (done_a)
                    begin
                        state_reg <= ST_SUM1;
                    end
                end
                ST_SUM1:      state_reg <= ST_SUM2;
                ST_SUM2:      state_reg <= ST_ABS;
                ST_ABS:       state_reg <= ST_CHK;
                ST_CHK:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT:       state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            err_mag_reg <= err_w[FIELD_W] ? err_neg_w[FIELD_W-1:0] : err_w[FIELD_W-1:0];
            dlt_mag_reg <= dlt_w[FIELD_W+1] ? dlt_neg_w[FIELD_W:0] : dlt_w[FIELD_W:0];
            sign_a_reg  <= kp_gain_reg[FIELD_W-1] ^ err_w[FIELD_W];
            sign_b_reg  <= kd_gain_reg[FIELD_W-1] ^ dlt_w[FIELD_W+1];
        end

        unique case (state_reg)
            ST_SUM1:
            begin
                num_reg <= sign_a_reg ? -prod_a : prod_a;
            end
            ST_SUM2:
            begin
                num_reg <= sign_b_reg ? (num_reg - term_b) : (num_reg + term_b);
            end
            ST_ABS:
            begin
                neg_reg <= num_reg[MUL_P_W-1];
                mag_reg <= num_reg[MUL_P_W-1] ? num_neg_w[MUL_P_W-2:0]
                                              : num_reg[MUL_P_W-2:0];
            end
            ST_CHK:
            begin
                // quotient of 2^16 or more saturates either way
                ovf_reg <= mag_reg[47:24] >= {8'b0, period_eff};
                rem_reg <= mag_reg[39:24];
                quo_reg <= mag_reg[23:8];
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? div_try_w[FIELD_W-1:0]
                                  : div_cat_w[FIELD_W-1:0];
                quo_reg <= {quo_reg[FIELD_W-2:0], div_ge};
            end
            ST_SAT:
            begin
                if (!neg_reg)
                begin
                    corr_reg <= (ovf_reg || quo_reg[FIELD_W-1]) ? CORR_MAX : quo_reg;
                end
                else
                begin
                    corr_reg <= (ovf_reg || (quo_reg > CORR_MIN)) ? CORR_MIN : quo_neg_w;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    right_speed_reg <= clamp_speed(rsp_w, min_speed_reg, max_speed_reg);
                    left_speed_reg  <= clamp_speed(lsp_w, min_speed_reg, max_speed_reg);
                    correction_reg  <= corr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_KP:     prdata = {16'b0, kp_gain_reg};
            REG_KD:     prdata = {16'b0, kd_gain_reg};
            REG_PERIOD: prdata = {16'b0, sample_period_reg};
            REG_RBASE:  prdata = {16'b0, right_base_reg};
            REG_LBASE:  prdata = {16'b0, left_base_reg};
            REG_MIN:    prdata = {16'b0, min_speed_reg};
            REG_MAX:    prdata = {16'b0, max_speed_reg};
            default:    prdata = '0;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign right_speed = right_speed_reg;
    assign left_speed  = left_speed_reg;
    assign correction  = correction_reg;

endmodule

// ===== sv/pdd_sermul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pdd_pkg for widths and step count.
module pdd_sermul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pdd_pkg::MUL_A_W-1:0]  mcand,
    input  logic [pdd_pkg::MUL_B_W-1:0]  mplier,
    output logic [pdd_pkg::MUL_P_W-1:0]  product,
    output logic                         done
);
    import pdd_pkg::*;

    logic [MUL_A_W-1:0]   mcand_reg;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_P_W-1:0]   prod_next;
    logic [MUL_A_W:0]     sum_w;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // high half accumulates, low half holds remaining multiplier bits
    assign sum_w     = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]}
                     + (prod_reg[0] ? {1'b0, mcand_reg} : {(MUL_A_W+1){1'b0}});
    assign prod_next = {sum_w, prod_reg[MUL_B_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == MUL_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            prod_reg  <= {{MUL_A_W{1'b0}}, mplier};
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;
    assign done    = done_reg;

endmodule

// ===== sv/pd_differential_drive_core_checker.sv =====
// Port-level checks for the differential drive PD controller, bound to the top level.
// Depends on pdd_pkg and pd_differential_drive_core_assert.svh.
`include "pd_differential_drive_core_assert.svh"

module pd_differential_drive_core_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [pdd_pkg::APB_ADDR_W-1:0]   paddr,
    input logic [pdd_pkg::APB_DATA_W-1:0]   pwdata,
    input logic [pdd_pkg::APB_DATA_W-1:0]   prdata,
    input logic                             pready,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [pdd_pkg::FIELD_W-1:0]      right_speed,
    input logic [pdd_pkg::FIELD_W-1:0]      left_speed,
    input logic [pdd_pkg::FIELD_W-1:0]      correction
);
    import pdd_pkg::*;

    logic [3*FIELD_W-1:0] out_bundle;
    logic                 kp_sel;
    logic                 kp_wr;

    assign out_bundle = {right_speed, left_speed, correction};
    assign kp_sel     = (paddr[APB_ADDR_W-1:2] == REG_KP);
    assign kp_wr      = psel && penable && pwrite && pready && kp_sel;

    // one item in flight: input closes right after a transfer
    `PDD_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
    // a result never appears the cycle after its input
    `PDD_ASSERT_NEXT(a_no_instant_out, in_valid && in_ready, !$rose(out_valid))
    `PDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bundle))
    // gain written is read back
    `PDD_ASSERT_NOW(a_kp_readback, kp_wr ##1 kp_sel, prdata[15:0] == $past(pwdata[15:0]))

endmodule

bind pd_differential_drive_core pd_differential_drive_core_checker u_checker (.*);
